@@ rtl/core/tkd_pkg.sv @@
`timescale 1ns / 1ps

package tkd_pkg;

  // key event codes carried in key_event
  typedef enum logic [3:0] {
    EV_UP        = 4'd0,
    EV_DOWN      = 4'd1,
    EV_RIGHT     = 4'd2,
    EV_LEFT      = 4'd3,
    EV_HOME      = 4'd4,
    EV_END       = 4'd5,
    EV_DELETE    = 4'd6,
    EV_BACKSPACE = 4'd7,
    EV_ENTER     = 4'd8,
    EV_EOI       = 4'd9,
    EV_INSERT    = 4'd10
  } key_event_t;

  // escape sequence tracking, one-hot
  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_ESC    = 10'b00_0000_0010,
    ST_CSI    = 10'b00_0000_0100,
    ST_SS3    = 10'b00_0000_1000,
    ST_CSI1   = 10'b00_0001_0000,
    ST_CSI3   = 10'b00_0010_0000,
    ST_CSI4   = 10'b00_0100_0000,
    ST_SKIP   = 10'b00_1000_0000,
    ST_CSI1S  = 10'b01_0000_0000,
    ST_CSI1S5 = 10'b10_0000_0000
  } seq_state_t;

  // byte values of interest
  localparam logic [7:0] CH_ESC    = 8'h1b;
  localparam logic [7:0] CH_DEL    = 8'h7f;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_TILDE  = 8'h7e;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_UC_O   = 8'h4f;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_B   = 8'h42;
  localparam logic [7:0] CH_UC_C   = 8'h43;
  localparam logic [7:0] CH_UC_D   = 8'h44;
  localparam logic [7:0] CH_UC_F   = 8'h46;
  localparam logic [7:0] CH_UC_H   = 8'h48;
  localparam logic [7:0] CH_DIG_1  = 8'h31;
  localparam logic [7:0] CH_DIG_2  = 8'h32;
  localparam logic [7:0] CH_DIG_3  = 8'h33;
  localparam logic [7:0] CH_DIG_4  = 8'h34;
  localparam logic [7:0] CH_DIG_5  = 8'h35;
  localparam logic [7:0] CH_DIG_6  = 8'h36;

  // control bytes recognized in idle
  localparam logic [7:0] CTL_A = 8'd1;
  localparam logic [7:0] CTL_B = 8'd2;
  localparam logic [7:0] CTL_D = 8'd4;
  localparam logic [7:0] CTL_E = 8'd5;
  localparam logic [7:0] CTL_F = 8'd6;
  localparam logic [7:0] CTL_H = 8'd8;
  localparam logic [7:0] CTL_J = 8'd10;
  localparam logic [7:0] CTL_M = 8'd13;
  localparam logic [7:0] CTL_N = 8'd14;
  localparam logic [7:0] CTL_P = 8'd16;

  // one decoded key
  typedef struct packed {
    key_event_t  key_event;
    logic [6:0]  char_code;
  } key_result_t;

endpackage

@@ rtl/core/tkd_if.sv @@
`timescale 1ns / 1ps

// raw byte channel
interface tkd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       line_empty;

  modport source (output valid, output in_byte, output line_empty, input ready);
  modport sink (input valid, input in_byte, input line_empty, output ready);
endinterface

// key event channel
interface tkd_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] key_event;
  logic [6:0] char_code;

  modport source (output valid, output key_event, output char_code, input ready);
  modport sink (input valid, input key_event, input char_code, output ready);
endinterface

@@ rtl/core/tkd_decode.sv @@
`timescale 1ns / 1ps

module tkd_decode
  import tkd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  in_byte,
  input  logic        line_empty,
  output logic        emit,
  output key_result_t result
);

  seq_state_t state;
  seq_state_t state_next;

  // next state and event for the current byte
  always_comb begin
    state_next       = state;
    emit             = 1'b0;
    result.key_event = EV_UP;
    result.char_code = 7'd0;
    if (in_byte == CH_ESC) begin
      state_next = ST_ESC;
    end else begin
      state_next = ST_IDLE;
      unique case (state)
        ST_ESC: begin
          if (in_byte == CH_LBRACK) state_next = ST_CSI;
          else if (in_byte == CH_UC_O) state_next = ST_SS3;
        end
        ST_CSI: begin
          if (in_byte == CH_UC_A) begin
            emit = 1'b1; result.key_event = EV_UP;
          end else if (in_byte == CH_UC_B) begin
            emit = 1'b1; result.key_event = EV_DOWN;
          end else if (in_byte == CH_UC_C) begin
            emit = 1'b1; result.key_event = EV_RIGHT;
          end else if (in_byte == CH_UC_D) begin
            emit = 1'b1; result.key_event = EV_LEFT;
          end else if (in_byte == CH_DIG_1) begin
            state_next = ST_CSI1;
          end else if (in_byte == CH_DIG_3) begin
            state_next = ST_CSI3;
          end else if (in_byte == CH_DIG_4) begin
            state_next = ST_CSI4;
          end else if (in_byte == CH_DIG_2 || in_byte == CH_DIG_5 ||
                       in_byte == CH_DIG_6) begin
            state_next = ST_SKIP;
          end
        end
        ST_SS3: begin
          if (in_byte == CH_UC_H) begin
            emit = 1'b1; result.key_event = EV_HOME;
          end else if (in_byte == CH_UC_F) begin
            emit = 1'b1; result.key_event = EV_END;
          end
        end
        ST_CSI1: begin
          if (in_byte == CH_TILDE) begin
            emit = 1'b1; result.key_event = EV_HOME;
          end else if (in_byte == CH_SEMI) begin
            state_next = ST_CSI1S;
          end
        end
        ST_CSI3: begin
          if (in_byte == CH_TILDE) begin
            emit = 1'b1; result.key_event = EV_DELETE;
          end
        end
        ST_CSI4: begin
          if (in_byte == CH_TILDE) begin
            emit = 1'b1; result.key_event = EV_END;
          end
        end
        ST_SKIP: begin
          emit = 1'b0;
        end
        ST_CSI1S: begin
          if (in_byte == CH_DIG_5) state_next = ST_CSI1S5;
        end
        ST_CSI1S5: begin
          if (in_byte == CH_UC_C) begin
            emit = 1'b1; result.key_event = EV_END;
          end else if (in_byte == CH_UC_D) begin
            emit = 1'b1; result.key_event = EV_HOME;
          end
        end
        default: begin
          // idle: plain bytes and control shortcuts
          if (in_byte[7]) begin
            emit = 1'b0;
          end else if (in_byte == CH_DEL) begin
            emit = 1'b1; result.key_event = EV_BACKSPACE;
          end else if (in_byte < CH_SPACE) begin
            emit = 1'b1;
            unique case (in_byte)
              CTL_J, CTL_M: result.key_event = EV_ENTER;
              CTL_D:        result.key_event = line_empty ? EV_EOI : EV_DELETE;
              CTL_A:        result.key_event = EV_HOME;
              CTL_B:        result.key_event = EV_LEFT;
              CTL_E:        result.key_event = EV_END;
              CTL_F:        result.key_event = EV_RIGHT;
              CTL_H:        result.key_event = EV_BACKSPACE;
              CTL_N:        result.key_event = EV_DOWN;
              CTL_P:        result.key_event = EV_UP;
              default:      emit = 1'b0;
            endcase
          end else begin
            emit             = 1'b1;
            result.key_event = EV_INSERT;
            result.char_code = in_byte[6:0];
          end
        end
      endcase
    end
  end

  // sequence state advances once per decoded byte
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else if (step) begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/core/terminal_key_sequence_decoder.sv @@
`timescale 1ns / 1ps

// terminal key sequence decoder
// in_ch carries one raw terminal byte per transaction together with a flag
// that tells whether the edited line is empty. out_ch carries decoded key
// events: key_event, plus char_code for insert events (zero otherwise).
// each byte gives zero or one key event; escape prefixes and unknown bytes
// give none.
// the byte is captured in an input register and decoded there against the
// escape sequence state; a resulting event lands in an output register when
// the held byte moves on and stays valid on out_ch until it is taken.
// throughput is one byte per cycle unless a byte that gives an event meets
// a full output register that is not being taken. the input stays ready
// while an event waits in the output register as long as the input register
// is free or can move on; a byte that gives no event moves on regardless of
// the output side.
// reset (rst, synchronous) empties both registers and returns the sequence
// state to idle.
module terminal_key_sequence_decoder
  import tkd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  tkd_in_if.sink    in_ch,
  tkd_out_if.source out_ch
);

  logic        hold_valid;
  logic [7:0]  hold_byte;
  logic        hold_empty;
  logic        out_valid;
  key_result_t out_data;
  logic        emit;
  key_result_t result;
  logic        advance;

  // the held byte moves on unless it gives an event and the output is full and not taken
  assign advance     = hold_valid && (!emit || !out_valid || out_ch.ready);
  assign in_ch.ready = !hold_valid || advance;

  tkd_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .in_byte    (hold_byte),
    .line_empty (hold_empty),
    .emit       (emit),
    .result     (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ch.ready) begin
      hold_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      hold_byte  <= in_ch.in_byte;
      hold_empty <= in_ch.line_empty;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_data <= result;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.key_event = out_data.key_event;
  assign out_ch.char_code = out_data.char_code;

endmodule

@@ dv/key_event_checker.sv @@
`timescale 1ns / 1ps

// watches both channels, predicts the key event for every accepted byte and
// compares each event transaction against the oldest prediction
module key_event_checker
  import tkd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  tkd_in_if    in_ch,
  tkd_out_if   out_ch,
  output int   fail_count,
  output int   pending_keys,
  output int   keys_checked
);

  seq_state_t  esc_state;
  key_result_t expected_keys[$];
  key_result_t want_key;
  key_result_t new_key;
  int          mismatches;
  int          checked;

  // decode one byte against the escape state; returns 1 when a key comes out
  function automatic bit decode_key_byte(input logic [7:0] b, input logic empty,
                                         output key_result_t key);
    seq_state_t prev;
    bit         hit;
    prev = esc_state;
    hit = 1'b0;
    key.key_event = EV_UP;
    key.char_code = 7'd0;
    if (b == CH_ESC) begin
      // escape restarts a sequence from anywhere
      esc_state = ST_ESC;
    end else begin
      esc_state = ST_IDLE;
      case (prev)
        ST_ESC: begin
          if (b == CH_LBRACK) esc_state = ST_CSI;
          else if (b == CH_UC_O) esc_state = ST_SS3;
        end
        ST_CSI: begin
          case (b)
            CH_UC_A: begin hit = 1'b1; key.key_event = EV_UP; end
            CH_UC_B: begin hit = 1'b1; key.key_event = EV_DOWN; end
            CH_UC_C: begin hit = 1'b1; key.key_event = EV_RIGHT; end
            CH_UC_D: begin hit = 1'b1; key.key_event = EV_LEFT; end
            CH_DIG_1: esc_state = ST_CSI1;
            CH_DIG_3: esc_state = ST_CSI3;
            CH_DIG_4: esc_state = ST_CSI4;
            CH_DIG_2, CH_DIG_5, CH_DIG_6: esc_state = ST_SKIP;
            default: ;
          endcase
        end
        ST_SS3: begin
          if (b == CH_UC_H) begin hit = 1'b1; key.key_event = EV_HOME; end
          else if (b == CH_UC_F) begin hit = 1'b1; key.key_event = EV_END; end
        end
        ST_CSI1: begin
          if (b == CH_TILDE) begin hit = 1'b1; key.key_event = EV_HOME; end
          else if (b == CH_SEMI) esc_state = ST_CSI1S;
        end
        ST_CSI3: begin
          if (b == CH_TILDE) begin hit = 1'b1; key.key_event = EV_DELETE; end
        end
        ST_CSI4: begin
          if (b == CH_TILDE) begin hit = 1'b1; key.key_event = EV_END; end
        end
        ST_SKIP: ;
        ST_CSI1S: begin
          if (b == CH_DIG_5) esc_state = ST_CSI1S5;
        end
        ST_CSI1S5: begin
          if (b == CH_UC_C) begin hit = 1'b1; key.key_event = EV_END; end
          else if (b == CH_UC_D) begin hit = 1'b1; key.key_event = EV_HOME; end
        end
        default: begin
          // idle: high bytes are dropped, controls map to shortcuts
          if (b[7]) begin
            hit = 1'b0;
          end else if (b == CH_DEL) begin
            hit = 1'b1;
            key.key_event = EV_BACKSPACE;
          end else if (b < CH_SPACE) begin
            hit = 1'b1;
            case (b)
              CTL_J, CTL_M: key.key_event = EV_ENTER;
              CTL_D: key.key_event = empty ? EV_EOI : EV_DELETE;
              CTL_A: key.key_event = EV_HOME;
              CTL_B: key.key_event = EV_LEFT;
              CTL_E: key.key_event = EV_END;
              CTL_F: key.key_event = EV_RIGHT;
              CTL_H: key.key_event = EV_BACKSPACE;
              CTL_N: key.key_event = EV_DOWN;
              CTL_P: key.key_event = EV_UP;
              default: hit = 1'b0;
            endcase
          end else begin
            hit = 1'b1;
            key.key_event = EV_INSERT;
            key.char_code = b[6:0];
          end
        end
      endcase
    end
    return hit;
  endfunction

  initial begin
    esc_state = ST_IDLE;
    mismatches = 0;
    checked = 0;
    fail_count = 0;
    pending_keys = 0;
    keys_checked = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      esc_state = ST_IDLE;
      expected_keys.delete();
    end else begin
      // compare a delivered key event with the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        if (expected_keys.size() == 0) begin
          $error("unexpected key event transaction: key_event %0d char_code %0d",
                 out_ch.key_event, out_ch.char_code);
          mismatches++;
        end else begin
          want_key = expected_keys.pop_front();
          checked++;
          if (want_key.key_event !== out_ch.key_event) begin
            $error("key_event mismatch: expected %0d, actual %0d",
                   want_key.key_event, out_ch.key_event);
            mismatches++;
          end
          if (want_key.char_code !== out_ch.char_code) begin
            $error("char_code mismatch: expected %0d, actual %0d",
                   want_key.char_code, out_ch.char_code);
            mismatches++;
          end
        end
      end
      // predict from each accepted byte transaction
      if (in_ch.valid && in_ch.ready) begin
        if (decode_key_byte(in_ch.in_byte, in_ch.line_empty, new_key))
          expected_keys.push_back(new_key);
      end
    end
    fail_count <= mismatches;
    pending_keys <= expected_keys.size();
    keys_checked <= checked;
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import tkd_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  localparam int USEFUL_BYTES = 650;
  localparam int LONG_HOLD    = 200;
  localparam int DRAIN_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tkd_in_if  in_ch ();
  tkd_out_if out_ch ();

  int fail_count;
  int pending_keys;
  int keys_checked;
  int bytes_sent;
  int useful_bytes;
  int seqs_sent;
  bit in_burst;
  bit out_burst;

  always #5 clk = ~clk;

  terminal_key_sequence_decoder u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  key_event_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count   (fail_count),
    .pending_keys (pending_keys),
    .keys_checked (keys_checked)
  );

  // watchdog
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // offer one byte after a random gap and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic empty);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.line_empty <= empty;
    do @(posedge clk); while (!in_ch.ready);
    bytes_sent++;
  endtask

  task automatic send_bytes(input byte_q_t q);
    foreach (q[i]) send_byte(q[i], 1'($urandom_range(0, 1)));
  endtask

  // complete escape sequence of one of five shapes
  function automatic byte_q_t escape_seq(input int kind);
    byte_q_t q;
    q.push_back(CH_ESC);
    case (kind)
      0: begin
        q.push_back(CH_LBRACK);
        q.push_back(8'(CH_UC_A + $urandom_range(0, 3)));
      end
      1: begin
        q.push_back(CH_UC_O);
        q.push_back($urandom_range(0, 1) ? CH_UC_H : CH_UC_F);
      end
      2: begin
        q.push_back(CH_LBRACK);
        case ($urandom_range(0, 2))
          0: q.push_back(CH_DIG_1);
          1: q.push_back(CH_DIG_3);
          default: q.push_back(CH_DIG_4);
        endcase
        q.push_back(CH_TILDE);
      end
      3: begin
        q.push_back(CH_LBRACK);
        q.push_back(CH_DIG_1);
        q.push_back(CH_SEMI);
        q.push_back(CH_DIG_5);
        q.push_back($urandom_range(0, 1) ? CH_UC_C : CH_UC_D);
      end
      default: begin
        // swallowed parameter byte after [2, [5 or [6
        q.push_back(CH_LBRACK);
        case ($urandom_range(0, 2))
          0: q.push_back(CH_DIG_2);
          1: q.push_back(CH_DIG_5);
          default: q.push_back(CH_DIG_6);
        endcase
        q.push_back(8'($urandom_range(0, 255)));
      end
    endcase
    return q;
  endfunction

  // one random unit: printable, control, sequence, broken sequence or noise
  task automatic send_random_unit();
    int pick;
    int cut;
    logic [7:0] b;
    byte_q_t q;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
    if (pick < 30) begin
      send_byte(8'($urandom_range(32, 126)), 1'($urandom_range(0, 1)));
      useful_bytes++;
    end else if (pick < 45) begin
      b = ($urandom_range(0, 5) == 0) ? CH_DEL : 8'($urandom_range(0, 31));
      if (b == CH_ESC) b = CTL_D;
      send_byte(b, 1'($urandom_range(0, 1)));
      useful_bytes++;
    end else if (pick < 80) begin
      q = escape_seq($urandom_range(0, 4));
      send_bytes(q);
      useful_bytes += q.size();
      seqs_sent++;
    end else if (pick < 92) begin
      // sequence cut short by an unrelated byte or a fresh escape
      q = escape_seq($urandom_range(0, 4));
      cut = $urandom_range(1, q.size() - 1);
      while (q.size() > cut) void'(q.pop_back());
      q.push_back(($urandom_range(0, 3) == 0) ? CH_ESC : 8'($urandom_range(0, 255)));
      send_bytes(q);
      useful_bytes += q.size();
      seqs_sent++;
    end else begin
      b = $urandom_range(0, 1) ? 8'($urandom_range(128, 255)) : 8'($urandom_range(0, 255));
      send_byte(b, 1'($urandom_range(0, 1)));
    end
  endtask

  // key event receiver with random stalls and one long hold-off
  initial begin
    int stall;
    int taken;
    out_ch.ready <= 1'b0;
    taken = 0;
    out_burst = 1'b0;
    @(negedge rst);
    forever begin
      stall = out_burst ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      taken++;
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
      if (taken == 40) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
    end
  end

  // byte stimulus and verdict
  initial begin
    int drain;
    in_ch.valid <= 1'b0;
    in_ch.in_byte <= 8'd0;
    in_ch.line_empty <= 1'b0;
    bytes_sent = 0;
    useful_bytes = 0;
    seqs_sent = 0;
    in_burst = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // field extremes and idle decoding
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    send_byte(CH_SPACE, 1'b0);
    send_byte(CH_TILDE, 1'b1);
    send_byte(CH_DEL, 1'b0);
    send_byte(CTL_D, 1'b1);
    send_byte(CTL_D, 1'b0);
    send_byte(CTL_M, 1'b0);
    send_byte(CTL_P, 1'b1);
    // escape in the middle of a sequence restarts it
    send_byte(CH_ESC, 1'b0);
    send_byte(CH_LBRACK, 1'b0);
    send_byte(CH_ESC, 1'b1);
    send_byte(CH_UC_O, 1'b0);
    send_byte(CH_UC_H, 1'b1);
    // high byte ends a sequence silently
    send_byte(CH_ESC, 1'b0);
    send_byte(CH_LBRACK, 1'b1);
    send_byte(8'h80, 1'b0);
    // ctrl-left form of home
    send_byte(CH_ESC, 1'b1);
    send_byte(CH_LBRACK, 1'b0);
    send_byte(CH_DIG_1, 1'b1);
    send_byte(CH_SEMI, 1'b0);
    send_byte(CH_DIG_5, 1'b1);
    send_byte(CH_UC_D, 1'b0);
    // swallowed byte, then back to plain insert
    send_byte(CH_ESC, 1'b0);
    send_byte(CH_LBRACK, 1'b1);
    send_byte(CH_DIG_5, 1'b0);
    send_byte(CH_UC_A, 1'b1);
    send_byte(8'h61, 1'b0);

    while (useful_bytes < USEFUL_BYTES) send_random_unit();
    in_ch.valid <= 1'b0;

    // let outstanding key events drain, then give the pipeline time to settle
    drain = 0;
    do begin
      @(posedge clk);
      drain++;
    end while (pending_keys != 0 && drain < DRAIN_LIMIT);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("fed %0d bytes including %0d escape sequences, complete and broken",
             bytes_sent, seqs_sent);
    $display("checked %0d key events across random source gaps and sink stalls",
             keys_checked);
    if (fail_count == 0 && pending_keys == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
